@@ hw/rtl/ais_pkg.sv @@
// Types and constants shared by the alpha interior solidify block.
package ais_pkg;

  localparam int FW_W     = 12;
  localparam int FH_W     = 13;
  localparam int RAD_W    = 4;
  localparam int ALPHA_W  = 8;
  localparam int RUN_W    = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [RUN_W-1:0] RUN_SAT = 5'd31;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERIOR_RADIUS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SUPPORT_ALPHA   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ALPHA    = 3'd4;

  localparam logic [FW_W-1:0]    RST_FRAME_WIDTH     = 12'd1920;
  localparam logic [FH_W-1:0]    RST_FRAME_HEIGHT    = 13'd1080;
  localparam logic [RAD_W-1:0]   RST_INTERIOR_RADIUS = 4'd0;
  localparam logic [ALPHA_W-1:0] RST_SUPPORT_ALPHA   = 8'd255;
  localparam logic [ALPHA_W-1:0] RST_TARGET_ALPHA    = 8'd255;

  typedef struct packed {
    logic               command;
    logic [ALPHA_W-1:0] pixel_alpha;
  } ais_in_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] result_alpha;
    logic               frame_last;
  } ais_out_t;

endpackage

@@ hw/rtl/alpha_interior_solidify.sv @@
// Alpha interior solidify: square-window erosion test and alpha floor on a raster matte.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  pixel    | pixel_valid / pixel_stall  | pixel_item  (command, pixel_alpha)
//  result   | result_valid / result_stall| result_item (result_alpha, frame_last)
//  config   | cfg_we                     | cfg_index, cfg_data
//
// One transfer per cycle unless stalled; results go via stage 1 and the result register.
// The row store and the column run store each take one read and one write per cycle,
// which sets the rate. Results trail their pixel by r*W+r transfers; drain items flush
// the tail. Reset clears counters and reloads config; column runs are ignored in a
// frame's first row. A stall on result backs up into pixel_stall in the same cycle.
module alpha_interior_solidify #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [ais_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [ais_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    pixel_valid,
  output logic                                    pixel_stall,
  input  ais_pkg::ais_in_t                        pixel_item,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output ais_pkg::ais_out_t                       result_item
);

  import ais_pkg::*;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int CPW      = (COL_W > FW_W) ? COL_W : FW_W;
  localparam int SLOT_W   = $clog2(2 * MAX_RADIUS);
  localparam int RS_DEPTH = 2 * MAX_RADIUS * (2 ** COL_W);

  // configuration registers
  logic [FW_W-1:0]    frame_width;
  logic [FH_W-1:0]    frame_height;
  logic [RAD_W-1:0]   interior_radius;
  logic [ALPHA_W-1:0] support_alpha;
  logic [ALPHA_W-1:0] target_alpha;

  // per-frame copies
  logic [FW_W-1:0]    lat_w;
  logic [FH_W-1:0]    lat_h;
  logic [RAD_W-1:0]   lat_r;
  logic [ALPHA_W-1:0] lat_support;
  logic [ALPHA_W-1:0] lat_target;
  logic               lat_active;

  // position state
  logic [CPW-1:0]    in_column;
  logic [FH_W-1:0]   in_row;
  logic [SLOT_W-1:0] in_slot;
  logic [CPW-1:0]    out_column;
  logic [FH_W-1:0]   out_row;
  logic [SLOT_W-1:0] out_slot;
  logic [RUN_W-1:0]  row_run;

  // stage 1
  logic               s1_valid;
  logic               s1_emit;
  logic               s1_pass;
  logic [ALPHA_W-1:0] s1_alpha;
  logic               s1_last;
  logic               s1_col_en;
  logic               s1_run_ok;
  logic               s1_first;
  logic [RUN_W-1:0]   s1_win;
  logic [ALPHA_W-1:0] s1_target;
  logic [COL_W-1:0]   s1_xc;

  logic               accept;
  logic               s1_adv;
  logic               start;
  logic [FW_W-1:0]    fresh_w;
  logic [FH_W-1:0]    fresh_h;
  logic [RUN_W-1:0]   fresh_two_r;
  logic               fresh_active;
  logic [FW_W-1:0]    cur_w;
  logic [FH_W-1:0]    cur_h;
  logic [RAD_W-1:0]   cur_r;
  logic [ALPHA_W-1:0] cur_support;
  logic [ALPHA_W-1:0] cur_target;
  logic               cur_active;
  logic [RUN_W-1:0]   cur_two_r;
  logic [RUN_W-1:0]   cur_win;
  logic [SLOT_W-1:0]  slot_max;
  logic               is_pixel;
  logic               pass_px;
  logic               act_px;
  logic               drain_ok;
  logic               col_last;
  logic               row_last;
  logic [RUN_W-1:0]   row_base;
  logic [RUN_W-1:0]   run_new;
  logic               run_ok;
  logic               col_en;
  logic [CPW-1:0]     xc_full;
  logic               emit_px;
  logic               emit_any;
  logic               out_col_last;
  logic               out_last;

  logic                      rs_wr_en;
  logic [SLOT_W+COL_W-1:0]   rs_wr_addr;
  logic                      rs_rd_en;
  logic [SLOT_W+COL_W-1:0]   rs_rd_addr;
  logic [ALPHA_W-1:0]        rs_rd_data;
  logic                      col_wr_en;
  logic [COL_W-1:0]          col_wr_addr;
  logic [RUN_W-1:0]          col_wr_data;
  logic                      col_rd_en;
  logic [COL_W-1:0]          col_rd_addr;
  logic [RUN_W-1:0]          col_rd_data;

  logic [RUN_W-1:0]   col_eff;
  logic [RUN_W-1:0]   col_v;
  logic               interior;
  logic [ALPHA_W-1:0] raised;
  logic [ALPHA_W-1:0] res_alpha;

  assign s1_adv      = !result_valid || !result_stall;
  assign pixel_stall = s1_valid && !s1_adv;
  assign accept      = pixel_valid && !pixel_stall;

  // frame geometry, taken from the registers at frame start
  always_comb begin
    fresh_w      = (frame_width == '0) ? FW_W'(1) : frame_width;
    fresh_h      = (frame_height == '0) ? FH_W'(1) : frame_height;
    fresh_two_r  = {interior_radius, 1'b0};
    fresh_active = (interior_radius != '0) &&
                   (32'(interior_radius) <= MAX_RADIUS) &&
                   (32'(fresh_w) <= MAX_WIDTH) &&
                   (fresh_w > FW_W'(fresh_two_r)) &&
                   (fresh_h > FH_W'(fresh_two_r));
  end

  assign start = (pixel_item.command == CMD_PIXEL) && (in_column == '0) && (in_row == '0);

  always_comb begin
    cur_w       = start ? fresh_w : lat_w;
    cur_h       = start ? fresh_h : lat_h;
    cur_r       = start ? interior_radius : lat_r;
    cur_support = start ? support_alpha : lat_support;
    cur_target  = start ? target_alpha : lat_target;
    cur_active  = start ? fresh_active : lat_active;
    cur_two_r   = {cur_r, 1'b0};
    cur_win     = {cur_r, 1'b1};
    slot_max    = SLOT_W'(cur_two_r - RUN_W'(1));
  end

  always_comb begin
    is_pixel = (pixel_item.command == CMD_PIXEL) && (in_row < cur_h);
    pass_px  = is_pixel && !cur_active;
    act_px   = is_pixel && cur_active;
    drain_ok = !is_pixel && lat_active && (in_row >= lat_h);

    col_last = in_column == CPW'(cur_w - FW_W'(1));
    row_last = in_row == cur_h - FH_W'(1);

    row_base = (in_column == '0) ? '0 : row_run;
    if (pixel_item.pixel_alpha >= cur_support) begin
      run_new = (row_base == RUN_SAT) ? RUN_SAT : row_base + RUN_W'(1);
    end else begin
      run_new = '0;
    end
    run_ok = run_new >= cur_win;

    col_en  = act_px && (in_column >= CPW'(cur_two_r));
    xc_full = in_column - CPW'(cur_r);
    emit_px = (in_row > FH_W'(cur_r)) ||
              ((in_row == FH_W'(cur_r)) && (in_column >= CPW'(cur_r)));
    emit_any = (act_px && emit_px) || drain_ok;

    out_col_last = out_column == CPW'(cur_w - FW_W'(1));
    out_last     = out_col_last && (out_row == cur_h - FH_W'(1));
  end

  // memory ports
  assign rs_wr_en    = accept && act_px;
  assign rs_wr_addr  = {in_slot, in_column[COL_W-1:0]};
  assign rs_rd_en    = accept && emit_any;
  assign rs_rd_addr  = {out_slot, out_column[COL_W-1:0]};
  assign col_rd_en   = accept && col_en;
  assign col_rd_addr = xc_full[COL_W-1:0];
  assign col_wr_en   = s1_valid && s1_col_en && s1_adv;
  assign col_wr_addr = s1_xc;
  assign col_wr_data = col_v;

  ais_ram #(
    .WIDTH (ALPHA_W),
    .DEPTH (RS_DEPTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (rs_wr_en),
    .wr_addr (rs_wr_addr),
    .wr_data (pixel_item.pixel_alpha),
    .rd_en   (rs_rd_en),
    .rd_addr (rs_rd_addr),
    .rd_data (rs_rd_data)
  );

  ais_ram #(
    .WIDTH (RUN_W),
    .DEPTH (MAX_WIDTH)
  ) u_column_run (
    .clk     (clk),
    .wr_en   (col_wr_en),
    .wr_addr (col_wr_addr),
    .wr_data (col_wr_data),
    .rd_en   (col_rd_en),
    .rd_addr (col_rd_addr),
    .rd_data (col_rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      interior_radius <= RST_INTERIOR_RADIUS;
      support_alpha   <= RST_SUPPORT_ALPHA;
      target_alpha    <= RST_TARGET_ALPHA;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     frame_width     <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data[FH_W-1:0];
        REG_INTERIOR_RADIUS: interior_radius <= cfg_data[RAD_W-1:0];
        REG_SUPPORT_ALPHA:   support_alpha   <= cfg_data[ALPHA_W-1:0];
        REG_TARGET_ALPHA:    target_alpha    <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // frame and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_w       <= RST_FRAME_WIDTH;
      lat_h       <= RST_FRAME_HEIGHT;
      lat_r       <= RST_INTERIOR_RADIUS;
      lat_support <= RST_SUPPORT_ALPHA;
      lat_target  <= RST_TARGET_ALPHA;
      lat_active  <= 1'b0;
      in_column   <= '0;
      in_row      <= '0;
      in_slot     <= '0;
      out_column  <= '0;
      out_row     <= '0;
      out_slot    <= '0;
      row_run     <= '0;
    end else if (accept) begin
      if (start) begin
        lat_w       <= fresh_w;
        lat_h       <= fresh_h;
        lat_r       <= interior_radius;
        lat_support <= support_alpha;
        lat_target  <= target_alpha;
        lat_active  <= fresh_active;
      end
      if (pass_px) begin
        if (col_last && row_last) begin
          in_column <= '0;
          in_row    <= '0;
        end else if (col_last) begin
          in_column <= '0;
          in_row    <= in_row + FH_W'(1);
        end else begin
          in_column <= in_column + CPW'(1);
        end
      end
      if (act_px) begin
        row_run <= run_new;
        if (col_last) begin
          in_column <= '0;
          in_row    <= in_row + FH_W'(1);
          in_slot   <= (in_slot == slot_max) ? '0 : in_slot + SLOT_W'(1);
        end else begin
          in_column <= in_column + CPW'(1);
        end
      end
      if (emit_any) begin
        if (out_last) begin
          in_column  <= '0;
          in_row     <= '0;
          in_slot    <= '0;
          out_column <= '0;
          out_row    <= '0;
          out_slot   <= '0;
        end else if (out_col_last) begin
          out_column <= '0;
          out_row    <= out_row + FH_W'(1);
          out_slot   <= (out_slot == slot_max) ? '0 : out_slot + SLOT_W'(1);
        end else begin
          out_column <= out_column + CPW'(1);
        end
      end
    end
  end

  // stage 1: memory data returns
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!pixel_stall) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit   <= pass_px || emit_any;
      s1_pass   <= pass_px;
      s1_alpha  <= pixel_item.pixel_alpha;
      s1_last   <= pass_px ? (col_last && row_last) : (drain_ok && out_last);
      s1_col_en <= col_en;
      s1_run_ok <= run_ok;
      s1_first  <= in_row == '0;
      s1_win    <= cur_win;
      s1_target <= cur_target;
      s1_xc     <= xc_full[COL_W-1:0];
    end
  end

  always_comb begin
    col_eff = s1_first ? '0 : col_rd_data;
    if (s1_run_ok) begin
      col_v = (col_eff == RUN_SAT) ? RUN_SAT : col_eff + RUN_W'(1);
    end else begin
      col_v = '0;
    end
    interior  = s1_col_en && (col_v >= s1_win);
    raised    = (interior && (rs_rd_data < s1_target)) ? s1_target : rs_rd_data;
    res_alpha = s1_pass ? s1_alpha : raised;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_item.result_alpha <= res_alpha;
      result_item.frame_last   <= s1_last;
    end
  end

  a_col_no_collide: assert property (@(posedge clk) disable iff (rst)
    (col_wr_en && col_rd_en) |-> (col_wr_addr != col_rd_addr))
    else $error("column run read and write hit the same entry");

  a_rs_no_collide: assert property (@(posedge clk) disable iff (rst)
    (rs_wr_en && rs_rd_en) |-> (rs_wr_addr != rs_rd_addr))
    else $error("row store read and write hit the same entry");

  a_out_behind_in: assert property (@(posedge clk) disable iff (rst)
    out_row <= in_row)
    else $error("result position ran ahead of input position");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !pixel_stall)
    else $error("pixel stalled with empty pipe");

endmodule

@@ hw/rtl/ais_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ais_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/sv/alpha_interior_solidify_checker.sv @@
// Checker for the alpha interior solidify block: predicts each result and compares transfers.
`timescale 1ns / 1ps
module alpha_interior_solidify_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ais_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ais_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            pixel_valid,
  input  logic                            pixel_stall,
  input  ais_pkg::ais_in_t                pixel_item,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  ais_pkg::ais_out_t               result_item,
  output int                              fail_count,
  output int                              pending_results
);
  import ais_pkg::*;

  localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH;
  localparam int unsigned RUN_CAP = RUN_SAT;
  localparam int PRINT_CAP = 100;

  logic [FW_W-1:0]    reg_w;
  logic [FH_W-1:0]    reg_h;
  logic [RAD_W-1:0]   reg_r;
  logic [ALPHA_W-1:0] reg_sup;
  logic [ALPHA_W-1:0] reg_tgt;

  int unsigned fw, fh, fr, fsup, ftgt;
  bit          factive;

  logic [ALPHA_W-1:0] line_store [STORE_DEPTH];
  int unsigned        col_run [MAX_WIDTH];
  int unsigned        row_run, in_col, in_row, emitted;

  ais_out_t solidified_q [$];
  ais_out_t want;
  int       results_seen;

  function automatic void open_frame();
    fw = (reg_w == 0) ? 1 : reg_w;
    fh = (reg_h == 0) ? 1 : reg_h;
    fr = reg_r;
    fsup = reg_sup;
    ftgt = reg_tgt;
    factive = fr != 0 && fr <= MAX_RADIUS && fw <= MAX_WIDTH && fw > 2 * fr && fh > 2 * fr;
    foreach (col_run[i]) col_run[i] = 0;
    row_run = 0;
  endfunction

  function automatic void close_frame();
    in_col = 0;
    in_row = 0;
    emitted = 0;
  endfunction

  function automatic void advance_position();
    in_col++;
    if (in_col >= fw) begin
      in_col = 0;
      in_row++;
    end
  endfunction

  function automatic void queue_result(input ais_out_t item);
    solidified_q = {solidified_q, item};
  endfunction

  function automatic logic [ALPHA_W-1:0] stored_alpha(input int unsigned e);
    int unsigned idx;
    idx = ((e / fw) % (2 * fr)) * MAX_WIDTH + e % fw;
    return (idx < STORE_DEPTH) ? line_store[idx] : '0;
  endfunction

  function automatic void predict_transfer(input ais_in_t it);
    int unsigned win, delay, q, widx, xc, v, e;
    bit          interior, last;
    ais_out_t    res;
    if (it.command == CMD_PIXEL && in_col == 0 && in_row == 0) open_frame();
    if (it.command == CMD_PIXEL && in_row < fh) begin
      if (!factive) begin
        last = (in_col + 1 == fw) && (in_row + 1 == fh);
        res.result_alpha = it.pixel_alpha;
        res.frame_last = last;
        queue_result(res);
        if (last) close_frame();
        else advance_position();
      end else begin
        win = 2 * fr + 1;
        delay = fr * fw + fr;
        q = in_row * fw + in_col;
        widx = (in_row % (2 * fr)) * MAX_WIDTH + in_col;
        interior = 1'b0;
        if (in_col == 0) row_run = 0;
        if (it.pixel_alpha >= fsup) row_run = (row_run < RUN_CAP) ? row_run + 1 : RUN_CAP;
        else row_run = 0;
        if (in_col >= 2 * fr) begin
          xc = in_col - fr;
          if (xc < MAX_WIDTH) begin
            v = col_run[xc];
            if (row_run >= win) v = (v < RUN_CAP) ? v + 1 : RUN_CAP;
            else v = 0;
            col_run[xc] = v;
            interior = (v >= win);
          end
        end
        if (q >= delay) begin
          e = emitted;
          v = stored_alpha(e);
          if (interior && v < ftgt) v = ftgt;
          res.result_alpha = v[ALPHA_W-1:0];
          res.frame_last = (e + 1 == fw * fh);
          queue_result(res);
          emitted = e + 1;
        end
        if (widx < STORE_DEPTH) line_store[widx] = it.pixel_alpha;
        advance_position();
      end
    end else if (factive && in_row >= fh && emitted < fw * fh) begin
      e = emitted;
      res.result_alpha = stored_alpha(e);
      res.frame_last = (e + 1 == fw * fh);
      queue_result(res);
      emitted = e + 1;
      if (res.frame_last) close_frame();
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("%0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reg_w = RST_FRAME_WIDTH;
      reg_h = RST_FRAME_HEIGHT;
      reg_r = RST_INTERIOR_RADIUS;
      reg_sup = RST_SUPPORT_ALPHA;
      reg_tgt = RST_TARGET_ALPHA;
      close_frame();
      open_frame();
      solidified_q.delete();
      results_seen = 0;
      fail_count = 0;
      pending_results <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: reg_w = cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: reg_h = cfg_data[FH_W-1:0];
          REG_INTERIOR_RADIUS: reg_r = cfg_data[RAD_W-1:0];
          REG_SUPPORT_ALPHA: reg_sup = cfg_data[ALPHA_W-1:0];
          REG_TARGET_ALPHA: reg_tgt = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) predict_transfer(pixel_item);
      if (result_valid && !result_stall) begin
        if (solidified_q.size() == 0) begin
          report_mismatch($sformatf("result %0d: transfer with nothing outstanding", results_seen));
        end else begin
          want = solidified_q.pop_front();
          if (result_item.result_alpha !== want.result_alpha)
            report_mismatch($sformatf("result %0d: result_alpha got %0d want %0d", results_seen,
                                      result_item.result_alpha, want.result_alpha));
          if (result_item.frame_last !== want.frame_last)
            report_mismatch($sformatf("result %0d: frame_last got %0b want %0b", results_seen,
                                      result_item.frame_last, want.frame_last));
        end
        results_seen++;
      end
      pending_results <= solidified_q.size();
    end
  end

endmodule

@@ tb/sv/alpha_interior_solidify_test.sv @@
// Top of the alpha interior solidify testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module alpha_interior_solidify_test;
  import ais_pkg::*;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_RADIUS     = 8;
  localparam int ITEM_TARGET    = 550;
  localparam int FULL_RADIUS    = 4;
  localparam int HOLD_OFF       = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_stall;
  ais_in_t                pixel_item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  ais_out_t               result_item;

  logic holdoff_kick = 1'b0;
  int   fail_count;
  int   pending_results;
  int   items_sent = 0;
  int   burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alpha_interior_solidify #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_item  (pixel_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item (result_item)
  );

  alpha_interior_solidify_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) result_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .pixel_item     (pixel_item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_item    (result_item),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit holdoff_done;
    int pat_mode;
    int pat_left;
    int pat_phase;
    holdoff_done = 1'b0;
    pat_mode = 0;
    pat_left = 0;
    pat_phase = 0;
    forever begin
      @(posedge clk);
      if (holdoff_kick && !holdoff_done) begin
        holdoff_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(16, 96);
        end
        pat_left--;
        pat_phase++;
        case (pat_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= (pat_phase % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [ALPHA_W-1:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    pixel_valid <= 1'b1;
    pixel_item <= {cmd, a};
    do @(posedge clk); while (!(pixel_valid && !pixel_stall));
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_frame(input int unsigned w, h, r, sup, tgt);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= REG_INTERIOR_RADIUS;
    cfg_data <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_index <= REG_SUPPORT_ALPHA;
    cfg_data <= CFG_DATA_W'(sup);
    @(posedge clk);
    cfg_index <= REG_TARGET_ALPHA;
    cfg_data <= CFG_DATA_W'(tgt);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ALPHA_W-1:0] pick_alpha(input int unsigned sup);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ALPHA_W'($urandom);
      default: return ALPHA_W'($urandom_range(sup, 255));
    endcase
  endfunction

  task automatic run_frame(input int unsigned w, h, r, sup, tgt, input int hold_at);
    int unsigned ew, eh, flush;
    int          k, npix;
    bit          act;
    ew = (w == 0) ? 1 : w;
    eh = (h == 0) ? 1 : h;
    act = r != 0 && r <= MAX_RADIUS && ew <= MAX_WIDTH && ew > 2 * r && eh > 2 * r;
    flush = act ? r * ew + r : 0;
    npix = ew * eh;
    program_frame(w, h, r, sup, tgt);
    for (k = 0; k < npix; k++) begin
      if ($urandom_range(0, 19) == 0) send_item(CMD_DRAIN, ALPHA_W'($urandom));
      if (k == hold_at) holdoff_kick <= 1'b1;
      send_item(CMD_PIXEL, pick_alpha(sup));
    end
    for (k = 0; k < flush; k++)
      send_item(($urandom_range(0, 4) == 0) ? CMD_PIXEL : CMD_DRAIN, ALPHA_W'($urandom));
    repeat ($urandom_range(0, 2)) send_item(CMD_DRAIN, ALPHA_W'($urandom));
    wait_idle();
  endtask

  initial begin
    int unsigned rr, rw, rh, rs, rt;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_DRAIN, 8'hA5);
    send_item(CMD_DRAIN, 8'h5A);
    wait_idle();

    run_frame(5, 5, 1, 128, 200, -1);
    run_frame(3, 3, 1, 255, 0, -1);
    run_frame(3, 2, 0, 255, 255, -1);
    run_frame(2, 1, 1, 0, 255, -1);
    run_frame(9, 8, 4, 100, 180, -1);
    run_frame(4, 3, 15, 0, 255, -1);
    run_frame(0, 6, 1, 0, 0, -1);
    run_frame(5, 0, 2, 255, 0, -1);
    run_frame(12, 9, 2, 64, 250, 60);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1: rr = 0;
        15, 16: rr = 3;
        17: rr = $urandom_range(4, MAX_RADIUS);
        18: rr = $urandom_range(MAX_RADIUS + 1, 15);
        default: rr = $urandom_range(1, 2);
      endcase
      if (rr != 0 && rr <= FULL_RADIUS && $urandom_range(0, 4) != 0) begin
        rw = $urandom_range(2 * rr + 1, 2 * rr + 6);
        rh = $urandom_range(2 * rr + 1, 2 * rr + 3);
      end else begin
        rw = $urandom_range(1, 24);
        rh = $urandom_range(1, 8);
      end
      case ($urandom_range(0, 3))
        0: rs = 0;
        1: rs = 255;
        default: rs = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 3))
        0: rt = 0;
        1: rt = 255;
        default: rt = $urandom_range(0, 255);
      endcase
      run_frame(rw, rh, rr, rs, rt, -1);
    end

    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ais_pkg.sv
hw/rtl/ais_ram.sv
hw/rtl/alpha_interior_solidify.sv
tb/sv/alpha_interior_solidify_checker.sv
tb/sv/alpha_interior_solidify_test.sv
